>>> rtl/fpse_pkg.sv
// fpse_pkg: shared widths and types for the first-primes sum engine
// no dependencies; imported by fpse_rem_unit, first_primes_sum_engine_top and the bench
package fpse_pkg;

   localparam int CNT_W  = 17;   // request count width
   localparam int CAND_W = 21;   // candidate width, covers the largest count the port can carry
   localparam int DIV_W  = 11;   // odd trial divisor, sqrt of the largest candidate fits
   localparam int SQ_W   = 2 * DIV_W;
   localparam int SUM_W  = 40;
   localparam int LAST_W = 20;
   localparam int STEP_W = 5;    // counts CAND_W remainder steps

   typedef struct packed {
      logic done;      // remainder ready, one cycle
      logic is_zero;   // divisor divides the candidate
   } rem_stat_type;

endpackage

>>> rtl/first_primes_sum_engine_top.sv
// channel   | ports                                          | handshake
// request   | start, busy, req_prime_count                   | taken when start and not busy
// response  | rsp_valid, rsp_prime_sum, rsp_last_prime,      | one-cycle strobe, always taken
//           | rsp_bad_request                                |
//
// a good request above one runs trial division over odd candidates from 3 upward;
// each trial is a square compare followed by a run of the serial remainder unit
// (fpse_rem_unit), and each prime found takes one more compare, so a request's
// run time is data dependent; the response follows in the next cycle
// a bad request (zero or above MAX_PRIMES) answers on the next cycle and never goes busy
// reset is synchronous; the block is idle right after it, with no response pending
// the response cannot be stalled; start may be raised while the strobe is shown
// depends on fpse_pkg and fpse_rem_unit
module first_primes_sum_engine_top #(
   parameter int MAX_PRIMES = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [fpse_pkg::CNT_W-1:0]    req_prime_count,
   output logic                          rsp_valid,
   output logic [fpse_pkg::SUM_W-1:0]    rsp_prime_sum,
   output logic [fpse_pkg::LAST_W-1:0]   rsp_last_prime,
   output logic                          rsp_bad_request
);
   import fpse_pkg::*;

   localparam logic [CAND_W-1:0] MaxPrimesW = CAND_W'(MAX_PRIMES);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_REM   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CAND_W-1:0] cand_ff, cand_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  target_ff, target_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              valid_ff, valid_in;
   logic [SUM_W-1:0]  out_sum_ff, out_sum_in;
   logic [LAST_W-1:0] out_last_ff, out_last_in;
   logic              out_bad_ff, out_bad_in;

   logic              accept;
   logic              bad_count;
   logic [SQ_W-1:0]   div_sq;
   logic [CNT_W-1:0]  cnt_next;
   logic              rem_start;
   rem_stat_type      rem_stat;

   fpse_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (cand_ff),
      .divisor  (div_ff),
      .stat     (rem_stat)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign bad_count = (req_prime_count == '0) ||
                      ({{(CAND_W-CNT_W){1'b0}}, req_prime_count} > MaxPrimesW);
   assign div_sq    = {{DIV_W{1'b0}}, div_ff} * {{DIV_W{1'b0}}, div_ff};
   assign cnt_next  = cnt_ff + CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      cand_in     = cand_ff;
      div_in      = div_ff;
      cnt_in      = cnt_ff;
      target_in   = target_ff;
      sum_in      = sum_ff;
      valid_in    = 1'b0;
      out_sum_in  = out_sum_ff;
      out_last_in = out_last_ff;
      out_bad_in  = out_bad_ff;
      rem_start   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (bad_count) begin
                  valid_in    = 1'b1;
                  out_sum_in  = '0;
                  out_last_in = '0;
                  out_bad_in  = 1'b1;
               end else if (req_prime_count == CNT_W'(1)) begin
                  // the prime 2 alone
                  valid_in    = 1'b1;
                  out_sum_in  = SUM_W'(2);
                  out_last_in = LAST_W'(2);
                  out_bad_in  = 1'b0;
               end else begin
                  cand_in   = CAND_W'(3);
                  div_in    = DIV_W'(3);
                  cnt_in    = CNT_W'(1);
                  sum_in    = SUM_W'(2);
                  target_in = req_prime_count;
                  state_in  = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (div_sq > {{(SQ_W-CAND_W){1'b0}}, cand_ff}) begin
               // no divisor up to the root: candidate is prime
               cnt_in = cnt_next;
               sum_in = sum_ff + {{(SUM_W-CAND_W){1'b0}}, cand_ff};
               if (cnt_next == target_ff) begin
                  valid_in    = 1'b1;
                  out_sum_in  = sum_ff + {{(SUM_W-CAND_W){1'b0}}, cand_ff};
                  out_last_in = cand_ff[LAST_W-1:0];
                  out_bad_in  = 1'b0;
                  state_in    = ST_IDLE;
               end else begin
                  cand_in = cand_ff + CAND_W'(2);
                  div_in  = DIV_W'(3);
               end
            end else begin
               rem_start = 1'b1;
               state_in  = ST_REM;
            end
         end
         ST_REM: begin
            if (rem_stat.done) begin
               if (rem_stat.is_zero) begin
                  cand_in = cand_ff + CAND_W'(2);
                  div_in  = DIV_W'(3);
               end else begin
                  div_in = div_ff + DIV_W'(2);
               end
               state_in = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      div_ff      <= div_in;
      cnt_ff      <= cnt_in;
      target_ff   <= target_in;
      sum_ff      <= sum_in;
      out_sum_ff  <= out_sum_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_prime_sum   = out_sum_ff;
   assign rsp_last_prime  = out_last_ff;
   assign rsp_bad_request = out_bad_ff;

endmodule

>>> rtl/fpse_rem_unit.sv
// fpse_rem_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on fpse_pkg for widths and the status struct
module fpse_rem_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [fpse_pkg::CAND_W-1:0]   dividend,
   input  logic [fpse_pkg::DIV_W-1:0]    divisor,
   output fpse_pkg::rem_stat_type        stat
);
   import fpse_pkg::*;

   localparam logic [STEP_W-1:0] StepLast = STEP_W'(CAND_W - 1);

   logic [CAND_W-1:0] shift_ff, shift_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;
   logic [DIV_W-1:0]  diff;

   assign trial = {rem_ff, shift_ff[CAND_W-1]};
   // only used when trial >= divisor, so the difference fits DIV_W bits
   assign diff  = trial[DIV_W-1:0] - div_ff;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[CAND_W-2:0], 1'b0};
         // restore when the trial value is below the divisor
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff;
         end else begin
            rem_in = trial[DIV_W-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == StepLast) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      step_ff  <= step_in;
   end

   assign stat.done    = done_ff;
   assign stat.is_zero = (rem_ff == '0);

endmodule

>>> tb/first_primes_sum_engine_top_tb.sv
// first_primes_sum_engine_top_tb: self-checking bench for the first-primes sum engine
// predicts sum and last prime per request with a memoized prime table, checks each strobe
// depends on fpse_pkg and first_primes_sum_engine_top
module first_primes_sum_engine_top_tb;
   import fpse_pkg::*;

   localparam int MAX_PRIMES = 65536;
   localparam int IDLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 40;
   localparam int RANDOM_ITEMS = 80;

   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [LAST_W-1:0] last;
      logic              bad;
   } prime_total_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [CNT_W-1:0]    req_prime_count = '0;
   logic                busy;
   logic                rsp_valid;
   logic [SUM_W-1:0]    rsp_prime_sum;
   logic [LAST_W-1:0]   rsp_last_prime;
   logic                rsp_bad_request;

   int unsigned         prime_list[$];
   longint unsigned     prime_sums[$];
   prime_total_type     pending_totals[$];
   int                  wrong_total_count = 0;
   int                  idle_cycles = 0;

   first_primes_sum_engine_top #(
      .MAX_PRIMES(MAX_PRIMES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_prime_count(req_prime_count),
      .rsp_valid(rsp_valid),
      .rsp_prime_sum(rsp_prime_sum),
      .rsp_last_prime(rsp_last_prime),
      .rsp_bad_request(rsp_bad_request)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic prime_total_type predict_prime_total(input logic [CNT_W-1:0] count);
      prime_total_type total;
      int unsigned     cand;
      bit              is_prime;
      longint unsigned d;
      total = '0;
      if (count == 0 || count > MAX_PRIMES) begin
         total.bad = 1'b1;
         return total;
      end
      if (prime_list.size() == 0) begin
         prime_list.push_back(2);
         prime_sums.push_back(2);
      end
      cand = (prime_list.size() == 1) ? 3 : prime_list[$] + 2;
      while (prime_list.size() < count) begin
         is_prime = 1'b1;
         // odd primes found so far are enough divisors
         for (int k = 1; k < prime_list.size(); k++) begin
            d = prime_list[k];
            if (d * d > cand) break;
            if (cand % prime_list[k] == 0) begin
               is_prime = 1'b0;
               break;
            end
         end
         if (is_prime) begin
            prime_sums.push_back(prime_sums[$] + cand);
            prime_list.push_back(cand);
         end
         cand += 2;
      end
      total.sum  = SUM_W'(prime_sums[count-1]);
      total.last = LAST_W'(prime_list[count-1]);
      return total;
   endfunction

   // holds start high until the beat is taken; start stays up for a following beat
   task automatic request_primes(input logic [CNT_W-1:0] count);
      start <= 1'b1;
      req_prime_count <= count;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_totals.push_back(predict_prime_total(count));
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_totals_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_totals.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CNT_W-1:0] pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 22) return CNT_W'($urandom_range(MAX_PRIMES + 1, (1 << CNT_W) - 1));
      if (roll < 88) return CNT_W'($urandom_range(1, 32));
      return CNT_W'($urandom_range(33, 120));
   endfunction

   // zero and over-bound counts, with every count bit set somewhere
   task automatic test_bad_counts();
      request_primes('0);
      request_primes(CNT_W'(MAX_PRIMES + 1));
      request_primes('1);
      request_primes(CNT_W'(17'h15555));
      request_primes(CNT_W'(17'h1aaaa));
      hold_off(3);
      request_primes('0);
      wait_totals_drained();
   endtask

   // smallest good counts, back to back and with bad beats sent between them
   task automatic test_first_counts();
      request_primes(1);
      request_primes(2);
      request_primes('0);
      request_primes(3);
      hold_off(1);
      request_primes(4);
      request_primes(CNT_W'(MAX_PRIMES + 1));
      request_primes(5);
      request_primes(1);
      wait_totals_drained();
   endtask

   // larger counts; the bound itself would run far too long to simulate
   task automatic test_larger_counts();
      request_primes(100);
      request_primes(2);
      request_primes(255);
      hold_off(2);
      request_primes(64);
      wait_totals_drained();
   endtask

   task automatic test_random_counts();
      int sent;
      int burst;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            request_primes(pick_count());
            sent++;
         end
         if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2)
            wait_totals_drained();
         else if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, 12));
      end
      start <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bad_counts();
      test_first_counts();
      test_larger_counts();
      test_random_counts();
      @(posedge clock);
      while (pending_totals.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (wrong_total_count == 0)
         $display("PASS first_primes_sum_engine_top");
      else
         $display("FAIL first_primes_sum_engine_top");
      $finish;
   end

   always @(posedge clock) begin
      prime_total_type want;
      prime_total_type got;
      if (!reset && rsp_valid) begin
         got = '{sum: rsp_prime_sum, last: rsp_last_prime, bad: rsp_bad_request};
         if (pending_totals.size() == 0) begin
            wrong_total_count++;
            if (wrong_total_count <= 10)
               $display("unexpected result beat: sum %0d last %0d bad %0b",
                        got.sum, got.last, got.bad);
         end else begin
            want = pending_totals.pop_front();
            if (got.sum !== want.sum || got.last !== want.last || got.bad !== want.bad) begin
               wrong_total_count++;
               if (wrong_total_count <= 10)
                  $display("result mismatch: sum %0d/%0d last %0d/%0d bad %0b/%0b (exp/act)",
                           want.sum, got.sum, want.last, got.last, want.bad, got.bad);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL first_primes_sum_engine_top");
            $finish;
         end
      end
   end

endmodule

>>> sim.f
rtl/fpse_pkg.sv
rtl/fpse_rem_unit.sv
rtl/first_primes_sum_engine_top.sv
tb/first_primes_sum_engine_top_tb.sv
